FILE: src/mpi_pkg.sv
package mpi_pkg;

    // cordic shape
    localparam int CORDIC_STAGES = 28;
    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
    localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    localparam logic [31:0] ATAN_TURN [CORDIC_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
        32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
        32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
        32'd10, 32'd5
    };

    // daily motions, Q0.36 turns per day
    localparam logic [31:0] RATE_SUN =
        32'(((64'd1 << 36) * 64'd10000) / 64'd3652422);
    localparam logic [31:0] RATE_MOON =
        32'(((64'd1 << 36) * 64'd131763966) / 64'd3600000000);
    localparam logic [31:0] RATE_PERI =
        32'(((64'd1 << 36) * 64'd1114041) / 64'd3600000000);

    // epoch longitudes, Q0.32 turns
    localparam logic [31:0] EPS_Q32 = 32'((64'd279611371 << 32) / 64'd360000000);
    localparam logic [31:0] RHO_Q32 = 32'((64'd282680403 << 32) / 64'd360000000);
    localparam logic [31:0] LZ_Q32  = 32'((64'd18251907 << 32) / 64'd360000000);
    localparam logic [31:0] PZ_Q32  = 32'((64'd192917585 << 32) / 64'd360000000);

    // term amplitudes, Q0.32 turns
    localparam logic signed [31:0] AMP_ECSUN  = 32'((64'd1915446 << 32) / 64'd360000000);
    localparam logic signed [31:0] AMP_EVEC   = 32'((64'd1273900 << 32) / 64'd360000000);
    localparam logic signed [31:0] AMP_ANNUAL = 32'((64'd185800 << 32) / 64'd360000000);
    localparam logic signed [31:0] AMP_THIRD  = 32'((64'd370000 << 32) / 64'd360000000);
    localparam logic signed [31:0] AMP_ECMOON = 32'((64'd6288600 << 32) / 64'd360000000);
    localparam logic signed [31:0] AMP_FOURTH = 32'((64'd214000 << 32) / 64'd360000000);
    localparam logic signed [31:0] AMP_VAR    = 32'((64'd658300 << 32) / 64'd360000000);

    // one day in Q16.16
    localparam logic [32:0] ONE_DAY = 33'd65536;

    // lit percentage thresholds in Q7.8 for whole-percent rounding
    localparam logic [14:0] PCT_FULL_MIN = 15'd25472;
    localparam logic [14:0] PCT_NEW_MAX  = 15'd127;
    localparam logic [14:0] PCT_MAX      = 15'd25600;

    typedef enum logic [2:0] {
        PH_NEW       = 3'd0,
        PH_WAX_CRES  = 3'd1,
        PH_FIRST_QTR = 3'd2,
        PH_WAX_GIBB  = 3'd3,
        PH_FULL      = 3'd4,
        PH_WANE_GIBB = 3'd5,
        PH_LAST_QTR  = 3'd6,
        PH_WANE_CRES = 3'd7
    } phase_t;

endpackage

FILE: src/mpi_cordic.sv
module mpi_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         in_angle,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic signed [32:0]  out_sin,
    output logic signed [32:0]  out_cos,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int N = mpi_pkg::CORDIC_STAGES;

    logic signed [32:0] x_reg [N];
    logic signed [32:0] y_reg [N];
    logic signed [33:0] z_reg [N];
    logic signed [32:0] x_next [N];
    logic signed [32:0] y_next [N];
    logic signed [33:0] z_next [N];
    logic [SIDE_W-1:0]  side_reg [N];
    logic [N-1:0]       v_reg;
    logic [N-1:0]       flip_reg;

    logic [31:0]        t_plus;
    logic               flip0;
    logic [31:0]        t_fold;
    logic signed [33:0] z0;

    logic signed [32:0] sin_reg;
    logic signed [32:0] cos_reg;
    logic [SIDE_W-1:0]  oside_reg;
    logic               ov_reg;

    // fold the angle into the right half plane
    assign t_plus = in_angle + 32'h4000_0000;
    assign flip0  = t_plus[31];
    assign t_fold = flip0 ? (in_angle + 32'h8000_0000) : in_angle;
    assign z0     = 34'(signed'(t_fold));

    // one rotation per stage
    always_comb
    begin
        logic signed [32:0] xp;
        logic signed [32:0] yp;
        logic signed [33:0] zp;
        for (int i = 0; i < N; i++)
        begin
            if (i == 0)
            begin
                xp = mpi_pkg::CORDIC_K;
                yp = '0;
                zp = z0;
            end
            else
            begin
                xp = x_reg[i-1];
                yp = y_reg[i-1];
                zp = z_reg[i-1];
            end
            if (zp >= 0)
            begin
                x_next[i] = xp - (yp >>> i);
                y_next[i] = yp + (xp >>> i);
                z_next[i] = zp - 34'(mpi_pkg::ATAN_TURN[i]);
            end
            else
            begin
                x_next[i] = xp + (yp >>> i);
                y_next[i] = yp - (xp >>> i);
                z_next[i] = zp + 34'(mpi_pkg::ATAN_TURN[i]);
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[N-2:0], in_valid};
            ov_reg <= v_reg[N-1];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg    <= {flip_reg[N-2:0], flip0};
            side_reg[0] <= in_side;
            for (int i = 0; i < N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
            for (int i = 1; i < N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            sin_reg   <= flip_reg[N-1] ? -y_reg[N-1] : y_reg[N-1];
            cos_reg   <= flip_reg[N-1] ? -x_reg[N-1] : x_reg[N-1];
            oside_reg <= side_reg[N-1];
        end
    end

    assign out_valid = ov_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;
    assign out_side  = oside_reg;

endmodule

FILE: src/mpi_lane.sv
module mpi_lane #(
    parameter int ANGLE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [32:0] day,
    output logic        out_valid,
    output logic [14:0] lit
);

    localparam int A  = ANGLE_BITS;
    localparam int SH = 62 - ANGLE_BITS;
    localparam logic [A-1:0] EPS_A = A'(mpi_pkg::EPS_Q32 >> (32 - A));
    localparam logic [A-1:0] RHO_A = A'(mpi_pkg::RHO_Q32 >> (32 - A));
    localparam logic [A-1:0] LZ_A  = A'(mpi_pkg::LZ_Q32 >> (32 - A));
    localparam logic [A-1:0] PZ_A  = A'(mpi_pkg::PZ_Q32 >> (32 - A));

    function automatic logic [31:0] to_turn(input logic [A-1:0] a);
        to_turn = 32'(a) << (32 - A);
    endfunction

    function automatic logic [A-1:0] term_ang(input logic signed [61:0] p);
        term_ang = A'(p >>> SH);
    endfunction

    // stage 1: day times daily motions
    logic [64:0] p_sun, p_moon, p_peri;
    logic [A-1:0] n1_reg, lm1_reg, lp1_reg;
    logic v1_reg;
    assign p_sun  = 65'(day) * 65'(mpi_pkg::RATE_SUN);
    assign p_moon = 65'(day) * 65'(mpi_pkg::RATE_MOON);
    assign p_peri = 65'(day) * 65'(mpi_pkg::RATE_PERI);

    // stage 2: mean anomalies and longitudes
    logic [A-1:0] l2_next;
    logic [A-1:0] n2_reg, l2_reg, mm2_reg, msol2_reg;
    logic v2_reg;
    assign l2_next = lm1_reg + LZ_A;

    // sun anomaly rotation
    logic c1_v;
    logic signed [32:0] c1_sin;
    logic [3*A-1:0] c1_side;
    logic [A-1:0] n_c1, l_c1, mm_c1;
    assign {n_c1, l_c1, mm_c1} = c1_side;

    // stage 3: sun terms
    logic signed [61:0] pe3_reg, pa3_reg, pt3_reg;
    logic [A-1:0] n3_reg, l3_reg, mm3_reg;
    logic v3_reg;

    // stage 4: sun longitude
    logic [A-1:0] lsol4_reg, l4_reg, mm4_reg, ac4_reg, a34_reg;
    logic v4_reg;

    // stage 5: evection angle
    logic [A-1:0] ang5_reg, lsol5_reg, l5_reg, mm5_reg, ac5_reg, a35_reg;
    logic v5_reg;

    // evection rotation
    logic c2_v;
    logic signed [32:0] c2_sin;
    logic [5*A-1:0] c2_side;
    logic [A-1:0] l_c2, lsol_c2, mm_c2, ac_c2, a3_c2;
    assign {l_c2, lsol_c2, mm_c2, ac_c2, a3_c2} = c2_side;

    // stage 6: evection product
    logic signed [61:0] pv6_reg;
    logic [A-1:0] l6_reg, lsol6_reg, mm6_reg, ac6_reg, a36_reg;
    logic v6_reg;

    // stage 7: corrected anomaly
    logic [A-1:0] ev7_next;
    logic [A-1:0] mmp7_reg, ev7_reg, ac7_reg, l7_reg, lsol7_reg;
    logic v7_reg;
    assign ev7_next = term_ang(pv6_reg);

    // center and fourth-term rotations
    logic c3_v;
    logic signed [32:0] c3_sin, c4_sin;
    logic [3*A-1:0] c3_side;
    logic [A-1:0] c4_side;
    logic [A-1:0] l_c3, lsol_c3, ac_c3;
    assign {l_c3, lsol_c3, ac_c3} = c3_side;

    // stage 8: center and fourth-term products
    logic signed [61:0] pe8_reg, pf8_reg;
    logic [A-1:0] l8_reg, lsol8_reg, ev8_reg, ac8_reg;
    logic v8_reg;

    // stage 9: true longitude
    logic [A-1:0] lp9_reg, lsol9_reg;
    logic v9_reg;

    // stage 10: variation angle
    logic [A-1:0] ang10_reg, lp10_reg, lsol10_reg;
    logic v10_reg;

    // variation rotation
    logic c5_v;
    logic signed [32:0] c5_sin;
    logic [2*A-1:0] c5_side;
    logic [A-1:0] lp_c5, lsol_c5;
    assign {lp_c5, lsol_c5} = c5_side;

    // stage 11: variation product
    logic signed [61:0] pvar11_reg;
    logic [A-1:0] lp11_reg, lsol11_reg;
    logic v11_reg;

    // stage 12: age of the moon
    logic [A-1:0] dd12_reg;
    logic v12_reg;

    // age rotation
    logic c6_v;
    logic signed [32:0] c6_cos;

    // stage 13: clamp and scale
    logic signed [32:0] cc13;
    logic [31:0] diff13;
    logic [45:0] prod13_reg;
    logic v13_reg;

    // stage 14: round
    logic [45:0] sum14;
    logic [14:0] lit14_reg;
    logic v14_reg;

    always_comb
    begin
        if (c6_cos > mpi_pkg::ONE_Q30)
        begin
            cc13 = mpi_pkg::ONE_Q30;
        end
        else if (c6_cos < -mpi_pkg::ONE_Q30)
        begin
            cc13 = -mpi_pkg::ONE_Q30;
        end
        else
        begin
            cc13 = c6_cos;
        end
    end
    assign diff13 = 32'(mpi_pkg::ONE_Q30 - cc13);
    assign sum14  = prod13_reg + 46'd536870912;

    // valid bits outside the rotation units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
            v14_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= c1_v;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= c2_v;
            v7_reg  <= v6_reg;
            v8_reg  <= c3_v;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= c5_v;
            v12_reg <= v11_reg;
            v13_reg <= c6_v;
            v14_reg <= v13_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= p_sun[51 -: A];
            lm1_reg <= p_moon[51 -: A];
            lp1_reg <= p_peri[51 -: A];

            n2_reg    <= n1_reg;
            l2_reg    <= l2_next;
            mm2_reg   <= l2_next - lp1_reg - PZ_A;
            msol2_reg <= n1_reg + EPS_A - RHO_A;

            pe3_reg <= c1_sin * mpi_pkg::AMP_ECSUN;
            pa3_reg <= c1_sin * mpi_pkg::AMP_ANNUAL;
            pt3_reg <= c1_sin * mpi_pkg::AMP_THIRD;
            n3_reg  <= n_c1;
            l3_reg  <= l_c1;
            mm3_reg <= mm_c1;

            lsol4_reg <= n3_reg + term_ang(pe3_reg) + EPS_A;
            ac4_reg   <= term_ang(pa3_reg);
            a34_reg   <= term_ang(pt3_reg);
            l4_reg    <= l3_reg;
            mm4_reg   <= mm3_reg;

            ang5_reg  <= ((l4_reg - lsol4_reg) << 1) - mm4_reg;
            lsol5_reg <= lsol4_reg;
            l5_reg    <= l4_reg;
            mm5_reg   <= mm4_reg;
            ac5_reg   <= ac4_reg;
            a35_reg   <= a34_reg;

            pv6_reg   <= c2_sin * mpi_pkg::AMP_EVEC;
            l6_reg    <= l_c2;
            lsol6_reg <= lsol_c2;
            mm6_reg   <= mm_c2;
            ac6_reg   <= ac_c2;
            a36_reg   <= a3_c2;

            mmp7_reg  <= mm6_reg + ev7_next - ac6_reg - a36_reg;
            ev7_reg   <= ev7_next;
            ac7_reg   <= ac6_reg;
            l7_reg    <= l6_reg;
            lsol7_reg <= lsol6_reg;

            pe8_reg   <= c3_sin * mpi_pkg::AMP_ECMOON;
            pf8_reg   <= c4_sin * mpi_pkg::AMP_FOURTH;
            l8_reg    <= l_c3;
            lsol8_reg <= lsol_c3;
            ac8_reg   <= ac_c3;
            ev8_reg   <= c4_side;

            lp9_reg   <= l8_reg + ev8_reg + term_ang(pe8_reg) - ac8_reg
                         + term_ang(pf8_reg);
            lsol9_reg <= lsol8_reg;

            ang10_reg  <= (lp9_reg - lsol9_reg) << 1;
            lp10_reg   <= lp9_reg;
            lsol10_reg <= lsol9_reg;

            pvar11_reg <= c5_sin * mpi_pkg::AMP_VAR;
            lp11_reg   <= lp_c5;
            lsol11_reg <= lsol_c5;

            dd12_reg <= lp11_reg + term_ang(pvar11_reg) - lsol11_reg;

            prod13_reg <= 46'(diff13) * 46'd12800;

            lit14_reg <= sum14[44:30];
        end
    end

    mpi_cordic #(.SIDE_W(3 * A)) u_rot_sun (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2_reg), .in_angle(to_turn(msol2_reg)),
        .in_side({n2_reg, l2_reg, mm2_reg}),
        .out_valid(c1_v), .out_sin(c1_sin), .out_cos(), .out_side(c1_side)
    );

    mpi_cordic #(.SIDE_W(5 * A)) u_rot_evec (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v5_reg), .in_angle(to_turn(ang5_reg)),
        .in_side({l5_reg, lsol5_reg, mm5_reg, ac5_reg, a35_reg}),
        .out_valid(c2_v), .out_sin(c2_sin), .out_cos(), .out_side(c2_side)
    );

    mpi_cordic #(.SIDE_W(3 * A)) u_rot_center (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v7_reg), .in_angle(to_turn(mmp7_reg)),
        .in_side({l7_reg, lsol7_reg, ac7_reg}),
        .out_valid(c3_v), .out_sin(c3_sin), .out_cos(), .out_side(c3_side)
    );

    mpi_cordic #(.SIDE_W(A)) u_rot_fourth (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v7_reg), .in_angle(to_turn(A'(mmp7_reg << 1))),
        .in_side(ev7_reg),
        .out_valid(), .out_sin(c4_sin), .out_cos(), .out_side(c4_side)
    );

    mpi_cordic #(.SIDE_W(2 * A)) u_rot_var (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v10_reg), .in_angle(to_turn(ang10_reg)),
        .in_side({lp10_reg, lsol10_reg}),
        .out_valid(c5_v), .out_sin(c5_sin), .out_cos(), .out_side(c5_side)
    );

    mpi_cordic #(.SIDE_W(A)) u_rot_age (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v12_reg), .in_angle(to_turn(dd12_reg)),
        .in_side(dd12_reg),
        .out_valid(c6_v), .out_sin(), .out_cos(c6_cos), .out_side()
    );

    assign out_valid = v14_reg;
    assign lit       = lit14_reg;

endmodule

FILE: src/moon_phase_illumination.sv
// channel  signals                                       dir  beat
// day      day_valid, day_ready, days_since_epoch         in   one day count, Q16.16
// result   res_valid, res_ready, illumination_pct,        out  percent lit Q7.8, phase class
//          phase_class
//
// one day count enters per cycle while the skid entry is free; the pipeline is 5 x 29 cordic
// stages plus 16 arithmetic and handshake stages, set by the chain of five dependent rotations.
// two identical lanes evaluate the day and the day after for waxing/waning.
// reset clears every valid bit; no clearing pass is needed.
// a result that is not taken moves to a skid register as the pipeline advances,
// and all stages then hold until the skid entry is taken.
module moon_phase_illumination #(
    parameter int ANGLE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        day_valid,
    output logic        day_ready,
    input  logic [31:0] days_since_epoch,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [14:0] illumination_pct,
    output logic [2:0]  phase_class
);

    logic        en;
    logic        v0_reg;
    logic [32:0] d0_reg;
    logic [32:0] d1_reg;

    logic        lane0_v, lane1_v;
    logic [14:0] now_lit, next_lit;

    logic [15:0]          rsum;
    logic [7:0]           rpct;
    logic                 wax;
    mpi_pkg::phase_t      cls_next;

    logic                 vc_reg;
    logic [14:0]          pct_reg;
    mpi_pkg::phase_t      cls_reg;

    logic                 skid_valid_reg;
    logic [14:0]          skid_pct_reg;
    mpi_pkg::phase_t      skid_cls_reg;

    // pipeline moves whenever the skid entry is free
    assign en        = !skid_valid_reg;
    assign day_ready = en;

    // input beat and the day after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= day_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg <= 33'(days_since_epoch);
            d1_reg <= 33'(days_since_epoch) + mpi_pkg::ONE_DAY;
        end
    end

    mpi_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_now (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v0_reg), .day(d0_reg),
        .out_valid(lane0_v), .lit(now_lit)
    );

    mpi_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_next (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v0_reg), .day(d1_reg),
        .out_valid(lane1_v), .lit(next_lit)
    );

    // phase class from the rounded percentage and the trend
    assign rsum = 16'(now_lit) + 16'd128;
    assign rpct = rsum[15:8];
    assign wax  = next_lit > now_lit;

    always_comb
    begin
        if (rpct == 8'd100)
        begin
            cls_next = mpi_pkg::PH_FULL;
        end
        else if (rpct == 8'd0)
        begin
            cls_next = mpi_pkg::PH_NEW;
        end
        else if (rpct == 8'd50)
        begin
            cls_next = wax ? mpi_pkg::PH_FIRST_QTR : mpi_pkg::PH_LAST_QTR;
        end
        else if (rpct > 8'd50)
        begin
            cls_next = wax ? mpi_pkg::PH_WAX_GIBB : mpi_pkg::PH_WANE_GIBB;
        end
        else
        begin
            cls_next = wax ? mpi_pkg::PH_WAX_CRES : mpi_pkg::PH_WANE_CRES;
        end
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= lane0_v & lane1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pct_reg <= now_lit;
            cls_reg <= cls_next;
        end
    end

    // skid entry catches a beat that was not taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (vc_reg && !res_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_pct_reg <= pct_reg;
            skid_cls_reg <= cls_reg;
        end
    end

    assign res_valid        = skid_valid_reg | vc_reg;
    assign illumination_pct = skid_valid_reg ? skid_pct_reg : pct_reg;
    assign phase_class      = skid_valid_reg ? skid_cls_reg : cls_reg;

endmodule

FILE: src/mpi_checker.sv
module mpi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [14:0] illumination_pct,
    input logic [2:0]  phase_class
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(illumination_pct)
                                    && $stable(phase_class))
        else $error("result beat changed while stalled");

    // lit percentage never exceeds the full disc
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> illumination_pct <= mpi_pkg::PCT_MAX)
        else $error("illumination above full disc");

    // full class exactly when the percentage rounds to one hundred
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((illumination_pct >= mpi_pkg::PCT_FULL_MIN)
                       == (phase_class == mpi_pkg::PH_FULL)))
        else $error("full class mismatch");

    // new class exactly when the percentage rounds to zero
    a_new: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((illumination_pct <= mpi_pkg::PCT_NEW_MAX)
                       == (phase_class == mpi_pkg::PH_NEW)))
        else $error("new class mismatch");

endmodule

bind moon_phase_illumination mpi_checker u_mpi_checker (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .illumination_pct(illumination_pct),
    .phase_class(phase_class)
);
